### sv/langevin_verlet_step_assert.svh
// Assertion macros for the Langevin velocity-Verlet step block
`ifndef LANGEVIN_VERLET_STEP_ASSERT_SVH
`define LANGEVIN_VERLET_STEP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define LVS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("langevin_verlet_step: assertion failed");
`define LVS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("langevin_verlet_step: assertion failed");
`else
`define LVS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define LVS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

### sv/lvs_pkg.sv
// Shared types, constants and widths for the Langevin velocity-Verlet step block
`timescale 1ns / 1ps
package lvs_pkg;

    localparam int FRAC_BITS = 16;

    localparam int WIDE_W = 64;
    localparam int ACC_W  = 128;
    localparam int SH_W   = 7;

    localparam logic [WIDE_W-1:0] WIDE_CAP     = (64'd1 << 62) - 64'd1;
    localparam logic [WIDE_W-1:0] THREE_PI_Q32 = 64'h0000_0009_6CBE_3F9A;
    localparam logic [WIDE_W-1:0] THREE_PI_Q   =
        (THREE_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic [WIDE_W-1:0] SIX_PI_Q     = THREE_PI_Q << 1;

    localparam logic [WIDE_W-1:0] LCG_MUL  = 64'h0000_0005_DEEC_E66D;
    localparam logic [47:0]       LCG_ADD  = 48'h0000_0000_000B;
    localparam logic [47:0]       RNG_SEED = 48'h1234_ABCD_330E;
    localparam logic [WIDE_W-1:0] RNG_HALF = 64'h0000_8000_0000_0000;

    localparam logic [SH_W-1:0] SH_NONE  = '0;
    localparam logic [SH_W-1:0] SH_FRAC  = SH_W'(FRAC_BITS);
    localparam logic [SH_W-1:0] SH_HALF  = SH_W'(FRAC_BITS + 1);
    localparam logic [SH_W-1:0] SH_NOISE = SH_W'(48);

    localparam int DIV_STEPS  = 64 + FRAC_BITS;
    localparam int SQRT_STEPS = 32;
    localparam int DCNT_W     = $clog2(DIV_STEPS);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [16:0] TIME_STEP_RST    = 17'd66;
    localparam logic [30:0] VISCOSITY_RST    = 31'd65536;
    localparam logic [30:0] TEMPERATURE_RST  = 31'd1638;
    localparam logic [30:0] UPDATE_DELAY_RST = 31'd3277;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP    = 2'd0,
        CFG_VISCOSITY    = 2'd1,
        CFG_TEMPERATURE  = 2'd2,
        CFG_UPDATE_DELAY = 2'd3
    } lvs_cfg_idx_t;

    typedef enum logic {
        CLS_PRE  = 1'b0,
        CLS_POST = 1'b1
    } lvs_class_t;

    typedef struct packed {
        logic               opcode;
        logic [31:0]        elapsed_time;
        logic               last_element;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] force_req;
        logic [30:0]        inverse_mass;
        logic [30:0]        radius;
    } lvs_in_t;

    typedef struct packed {
        logic signed [31:0] new_position;
        logic signed [31:0] new_velocity;
        logic signed [31:0] new_force;
        logic               saturated;
    } lvs_out_t;

    typedef struct packed {
        logic [16:0] time_step;
        logic [30:0] viscosity;
        logic [30:0] temperature;
        logic [30:0] update_delay;
    } lvs_cfg_t;

    typedef struct packed {
        lvs_class_t cls;
        lvs_in_t    item;
    } lvs_qent_t;

    typedef struct packed {
        logic [WIDE_W-1:0] a;
        logic [WIDE_W-1:0] b;
        logic [SH_W-1:0]   sh;
        logic              rnd;
        logic              sgn;
    } lvs_mul_req_t;

    typedef struct packed {
        logic [WIDE_W-1:0]        q_lo;
        logic [WIDE_W-1:0]        clip;
        logic signed [WIDE_W-1:0] sres;
        logic                     sat;
    } lvs_mul_res_t;

    typedef struct packed {
        logic idle;
        logic out_load;
    } lvs_bstat_t;

    typedef enum logic [4:0] {
        B_IDLE, B_HDT, B_KICK1, B_VEL1, B_DRIFT, B_POS,
        B_ER, B_CHK, B_DEN, B_NUM, B_ROOT, B_LCG, B_NOISE,
        B_COEF, B_DRAG, B_FORCE, B_KICK2, B_VEL2, B_OUT
    } lvs_bstate_t;

    typedef enum logic [1:0] {
        R_IDLE, R_DIV, R_SINIT, R_SQRT
    } lvs_rstate_t;

endpackage

### sv/lvs_front.sv
// Front end: accepts requests, tags them pre- or post-force, queues them
`timescale 1ns / 1ps
module lvs_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lvs_pkg::lvs_in_t   s_data,
    input  logic               pop,
    output logic               q_valid,
    output lvs_pkg::lvs_qent_t q_ent
);
    import lvs_pkg::*;

    lvs_qent_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]    count_reg;
    logic                 push;
    logic                 do_pop;
    lvs_qent_t            ent;

    assign s_ready = (count_reg != QCNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_ent   = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign do_pop  = pop && q_valid;

    always_comb begin
        ent.item = s_data;
        ent.cls  = s_data.opcode ? CLS_POST : CLS_PRE;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### sv/lvs_mul.sv
// Shared multiplier: 64x64 from four registered 32x32 partials, round, shift, clip
`timescale 1ns / 1ps
module lvs_mul (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  lvs_pkg::lvs_mul_req_t req,
    output logic                  done,
    output lvs_pkg::lvs_mul_res_t res
);
    import lvs_pkg::*;

    localparam logic [2:0] LAST_MUL = 3'd3;
    localparam logic [2:0] LAST_ACC = 3'd4;
    localparam logic [2:0] FINISH   = 3'd5;

    logic              busy_reg, done_reg;
    logic [2:0]        cnt_reg;
    logic [WIDE_W-1:0] a_reg, b_reg, p_reg;
    logic [SH_W-1:0]   sh_reg;
    logic              neg_reg;
    logic [1:0]        pidx_reg;
    logic [ACC_W-1:0]  acc_reg;
    lvs_mul_res_t      res_reg;

    logic [WIDE_W-1:0] a_mag, b_mag;
    logic [31:0]       a_half, b_half;
    logic [WIDE_W-1:0] prod;
    logic [ACC_W-1:0]  part;
    logic [ACC_W-1:0]  rnd_init;
    logic [ACC_W-1:0]  qv;
    lvs_mul_res_t      fin;

    assign done = done_reg;
    assign res  = res_reg;

    always_comb begin
        a_mag    = (req.sgn && req.a[WIDE_W-1]) ? (~req.a + 1'b1) : req.a;
        b_mag    = (req.sgn && req.b[WIDE_W-1]) ? (~req.b + 1'b1) : req.b;
        rnd_init = (req.rnd && (req.sh != '0)) ? (ACC_W'(1) << (req.sh - 1'b1)) : '0;
        a_half   = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        b_half   = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        prod     = {32'b0, a_half} * {32'b0, b_half};
        unique case (pidx_reg)
            2'd0:       part = ACC_W'(p_reg);
            2'd1, 2'd2: part = ACC_W'(p_reg) << 32;
            2'd3:       part = ACC_W'(p_reg) << 64;
        endcase
        qv       = acc_reg >> sh_reg;
        fin.q_lo = qv[WIDE_W-1:0];
        fin.sat  = |qv[ACC_W-1:62];
        fin.clip = fin.sat ? WIDE_CAP : {2'b00, qv[61:0]};
        fin.sres = neg_reg ? -$signed(fin.clip) : $signed(fin.clip);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == FINISH) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // rounding constant is preloaded into the accumulator
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a_mag;
            b_reg   <= b_mag;
            sh_reg  <= req.sh;
            neg_reg <= req.sgn && (req.a[WIDE_W-1] != req.b[WIDE_W-1]);
            acc_reg <= rnd_init;
        end else if (busy_reg) begin
            if (cnt_reg <= LAST_MUL) begin
                p_reg    <= prod;
                pidx_reg <= cnt_reg[1:0];
            end
            if ((cnt_reg != '0) && (cnt_reg <= LAST_ACC)) begin
                acc_reg <= acc_reg + part;
            end
            if (cnt_reg == FINISH) begin
                res_reg <= fin;
            end
        end
    end

endmodule

### sv/lvs_root.sv
// Noise scale unit: restoring divide num*2^F/den, then digit-by-digit square root
`timescale 1ns / 1ps
module lvs_root (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [lvs_pkg::WIDE_W-1:0]     num,
    input  logic [lvs_pkg::WIDE_W-1:0]     den,
    output logic                           done,
    output logic [lvs_pkg::WIDE_W-1:0]     scale
);
    import lvs_pkg::*;

    lvs_rstate_t       state_reg, state_next;
    logic [DCNT_W-1:0] cnt_reg;
    logic              done_reg;
    logic [WIDE_W-1:0] n_reg, d_reg, rem_reg, q_reg;
    logic              ovf_reg;
    logic [WIDE_W-1:0] s_reg, res_reg, bit_reg;

    logic [WIDE_W:0]   rem2, rem_sub, sum;
    logic              ge, sq_ge;

    assign done  = done_reg;
    assign scale = res_reg;

    always_comb begin
        rem2    = {rem_reg, n_reg[WIDE_W-1]};
        rem_sub = rem2 - {1'b0, d_reg};
        ge      = (rem2 >= {1'b0, d_reg});
        sum     = {1'b0, res_reg} + {1'b0, bit_reg};
        sq_ge   = ({1'b0, s_reg} >= sum);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            R_IDLE:  if (start) state_next = R_DIV;
            R_DIV:   if (cnt_reg == '0) state_next = R_SINIT;
            R_SINIT: state_next = R_SQRT;
            R_SQRT:  if (cnt_reg == '0) state_next = R_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == R_SQRT) && (cnt_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            R_IDLE: begin
                if (start) begin
                    n_reg   <= num;
                    d_reg   <= den;
                    rem_reg <= '0;
                    q_reg   <= '0;
                    ovf_reg <= 1'b0;
                    cnt_reg <= DCNT_W'(DIV_STEPS - 1);
                end
            end
            R_DIV: begin
                n_reg   <= n_reg << 1;
                rem_reg <= ge ? rem_sub[WIDE_W-1:0] : rem2[WIDE_W-1:0];
                // quotient beyond 64 bits clips to all ones
                ovf_reg <= ovf_reg | q_reg[WIDE_W-1];
                q_reg   <= {q_reg[WIDE_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            R_SINIT: begin
                s_reg   <= ovf_reg ? '1 : q_reg;
                res_reg <= '0;
                bit_reg <= WIDE_W'(1) << 62;
                cnt_reg <= DCNT_W'(SQRT_STEPS - 1);
            end
            R_SQRT: begin
                if (sq_ge) begin
                    s_reg   <= s_reg - sum[WIDE_W-1:0];
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg - 1'b1;
            end
        endcase
    end

endmodule

### sv/lvs_back.sv
// Back end: sequencer and datapath for kick, drift, noise, drag and output register
`timescale 1ns / 1ps
module lvs_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  lvs_pkg::lvs_cfg_t  cfg,
    input  logic               q_valid,
    input  lvs_pkg::lvs_qent_t q_ent,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output lvs_pkg::lvs_out_t  m_data,
    output lvs_pkg::lvs_bstat_t stat
);
    import lvs_pkg::*;

    function automatic logic [32:0] sat32(input logic signed [63:0] val);
        logic [32:0] r;
        if (val > 64'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (val < -64'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, val[31:0]};
        end
        return r;
    endfunction

    lvs_bstate_t state_reg, state_next;
    logic        issued_reg;

    lvs_class_t         cls_reg;
    logic [31:0]        now_reg;
    logic               last_reg;
    logic signed [31:0] x_reg, v_reg, f_reg;
    logic [30:0]        im_reg, r_reg;
    logic [WIDE_W-1:0]  hdt_reg, er_reg, den_reg, num_reg, scale_reg, coef_reg;
    logic signed [WIDE_W-1:0] t_reg, f1_reg;
    logic [31:0]        diff_reg;
    logic               sat_reg;
    logic [47:0]        rng_reg;
    logic [31:0]        last_noise_reg;
    logic               m_valid_reg;
    lvs_out_t           m_data_reg;

    lvs_mul_req_t mul_req;
    lvs_mul_res_t mul_res;
    logic         mul_start, mul_done, mul_state, mul_sat_en;
    logic         root_start, root_done, root_state;
    logic [WIDE_W-1:0] root_scale;
    logic         adv, out_load;

    logic signed [WIDE_W-1:0] v_ext, f_ext, x_ext;
    logic [32:0]  vel_sat, pos_sat, frc_sat;
    logic [32:0]  diff33;
    logic         noisy;

    lvs_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .req     (mul_req),
        .done    (mul_done),
        .res     (mul_res)
    );

    lvs_root u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .num     (num_reg),
        .den     (den_reg),
        .done    (root_done),
        .scale   (root_scale)
    );

    always_comb begin
        v_ext   = WIDE_W'(v_reg);
        f_ext   = WIDE_W'(f_reg);
        x_ext   = WIDE_W'(x_reg);
        vel_sat = sat32(v_ext + t_reg);
        pos_sat = sat32(x_ext + t_reg);
        frc_sat = sat32(f1_reg - t_reg);
        diff33  = {1'b0, now_reg} - {1'b0, last_noise_reg};
        noisy   = !diff33[32] && (diff33[31:0] > {1'b0, cfg.update_delay})
                  && (cfg.temperature != '0);
    end

    // outputs of the sequencer
    always_comb begin
        mul_req.a   = '0;
        mul_req.b   = '0;
        mul_req.sh  = SH_FRAC;
        mul_req.rnd = 1'b1;
        mul_req.sgn = 1'b0;
        mul_state   = 1'b1;
        mul_sat_en  = 1'b1;
        unique case (state_reg)
            B_HDT: begin
                mul_req.a  = WIDE_W'(cfg.time_step);
                mul_req.b  = WIDE_W'(im_reg);
                mul_req.sh = SH_HALF;
            end
            B_KICK1, B_KICK2: begin
                mul_req.a   = hdt_reg;
                mul_req.b   = f_ext;
                mul_req.sgn = 1'b1;
            end
            B_DRIFT: begin
                mul_req.a   = WIDE_W'(cfg.time_step);
                mul_req.b   = v_ext;
                mul_req.sgn = 1'b1;
            end
            B_ER: begin
                mul_req.a = WIDE_W'(cfg.viscosity);
                mul_req.b = WIDE_W'(r_reg);
            end
            B_DEN: begin
                mul_req.a = er_reg;
                mul_req.b = THREE_PI_Q;
            end
            B_NUM: begin
                mul_req.a   = WIDE_W'(cfg.temperature);
                mul_req.b   = WIDE_W'(diff_reg);
                mul_req.sh  = SH_NONE;
                mul_req.rnd = 1'b0;
                mul_sat_en  = 1'b0;
            end
            B_LCG: begin
                mul_req.a   = LCG_MUL;
                mul_req.b   = WIDE_W'(rng_reg);
                mul_req.sh  = SH_NONE;
                mul_req.rnd = 1'b0;
                mul_sat_en  = 1'b0;
            end
            B_NOISE: begin
                mul_req.a   = scale_reg;
                mul_req.b   = WIDE_W'(rng_reg) - RNG_HALF;
                mul_req.sh  = SH_NOISE;
                mul_req.sgn = 1'b1;
            end
            B_COEF: begin
                mul_req.a = er_reg;
                mul_req.b = SIX_PI_Q;
            end
            B_DRAG: begin
                mul_req.a   = coef_reg;
                mul_req.b   = v_ext;
                mul_req.sgn = 1'b1;
            end
            default: begin
                mul_state  = 1'b0;
                mul_sat_en = 1'b0;
            end
        endcase
        root_state    = (state_reg == B_ROOT);
        mul_start     = mul_state && !issued_reg;
        root_start    = root_state && !issued_reg;
        adv           = issued_reg && ((mul_state && mul_done) || (root_state && root_done));
        pop           = (state_reg == B_IDLE) && q_valid;
        out_load      = (state_reg == B_OUT) && (!m_valid_reg || m_ready);
        stat.idle     = (state_reg == B_IDLE);
        stat.out_load = out_load;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (q_valid) state_next = B_HDT;
            B_HDT:   if (adv) state_next = (cls_reg == CLS_PRE) ? B_KICK1 : B_ER;
            B_KICK1: if (adv) state_next = B_VEL1;
            B_VEL1:  state_next = B_DRIFT;
            B_DRIFT: if (adv) state_next = B_POS;
            B_POS:   state_next = B_OUT;
            B_ER:    if (adv) state_next = B_CHK;
            B_CHK:   state_next = noisy ? B_DEN : B_COEF;
            B_DEN:   if (adv) state_next = B_NUM;
            B_NUM:   if (adv) state_next = B_ROOT;
            B_ROOT:  if (adv) state_next = B_LCG;
            B_LCG:   if (adv) state_next = B_NOISE;
            B_NOISE: if (adv) state_next = B_COEF;
            B_COEF:  if (adv) state_next = B_DRAG;
            B_DRAG:  if (adv) state_next = B_FORCE;
            B_FORCE: state_next = B_KICK2;
            B_KICK2: if (adv) state_next = B_VEL2;
            B_VEL2:  state_next = B_OUT;
            B_OUT:   if (out_load) state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= B_IDLE;
            issued_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            rng_reg        <= RNG_SEED;
            last_noise_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (mul_start || root_start) begin
                issued_reg <= 1'b1;
            end else if (adv) begin
                issued_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if ((state_reg == B_LCG) && adv) begin
                rng_reg <= mul_res.q_lo[47:0] + LCG_ADD;
            end
            // noisy pass records its time on its last element
            if ((state_reg == B_CHK) && noisy && last_reg) begin
                last_noise_reg <= now_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && mul_sat_en) begin
            sat_reg <= sat_reg | mul_res.sat;
        end
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    cls_reg  <= q_ent.cls;
                    now_reg  <= q_ent.item.elapsed_time;
                    last_reg <= q_ent.item.last_element;
                    x_reg    <= q_ent.item.position;
                    v_reg    <= q_ent.item.velocity;
                    f_reg    <= q_ent.item.force_req;
                    im_reg   <= q_ent.item.inverse_mass;
                    r_reg    <= q_ent.item.radius;
                    sat_reg  <= 1'b0;
                end
            end
            B_HDT:   if (adv) hdt_reg <= mul_res.clip;
            B_KICK1, B_DRIFT, B_DRAG, B_KICK2: if (adv) t_reg <= mul_res.sres;
            B_VEL1, B_VEL2: begin
                v_reg   <= vel_sat[31:0];
                sat_reg <= sat_reg | vel_sat[32];
            end
            B_POS: begin
                x_reg   <= pos_sat[31:0];
                sat_reg <= sat_reg | pos_sat[32];
            end
            B_ER:    if (adv) er_reg <= mul_res.clip;
            B_CHK: begin
                diff_reg <= diff33[31:0];
                f1_reg   <= f_ext;
            end
            B_DEN: begin
                if (adv) den_reg <= (mul_res.clip == '0) ? WIDE_W'(1) : mul_res.clip;
            end
            B_NUM:   if (adv) num_reg <= mul_res.q_lo;
            B_ROOT:  if (adv) scale_reg <= root_scale;
            B_NOISE: if (adv) f1_reg <= f1_reg + mul_res.sres;
            B_COEF:  if (adv) coef_reg <= mul_res.clip;
            B_FORCE: begin
                f_reg   <= frc_sat[31:0];
                sat_reg <= sat_reg | frc_sat[32];
            end
            B_OUT: begin
                if (out_load) begin
                    m_data_reg.new_position <= x_reg;
                    m_data_reg.new_velocity <= v_reg;
                    m_data_reg.new_force    <= f_reg;
                    m_data_reg.saturated    <= sat_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### sv/langevin_verlet_step.sv
// One request at a time in the back end; each product on the shared 64x64 multiplier
// holds the sequencer until it is done, and a noisy post-force request also waits on
// the noise scale step (a divide, then a square root).
// A two-entry queue and the output register let input and output stall on their own.
// Reset (synchronous, active low) empties the queue and output, restores default
// registers, the generator seed and the last noise time.
`timescale 1ns / 1ps
`include "langevin_verlet_step_assert.svh"
module langevin_verlet_step (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lvs_pkg::lvs_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lvs_pkg::lvs_out_t                   m_data,
    input  logic                                cfg_wr_en,
    input  logic [lvs_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  logic [lvs_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);
    import lvs_pkg::*;

    lvs_cfg_t   cfg_reg;
    logic       q_valid, pop;
    lvs_qent_t  q_ent;
    lvs_bstat_t bstat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.time_step    <= TIME_STEP_RST;
            cfg_reg.viscosity    <= VISCOSITY_RST;
            cfg_reg.temperature  <= TEMPERATURE_RST;
            cfg_reg.update_delay <= UPDATE_DELAY_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_TIME_STEP:    cfg_reg.time_step    <= cfg_wr_data[16:0];
                CFG_VISCOSITY:    cfg_reg.viscosity    <= cfg_wr_data;
                CFG_TEMPERATURE:  cfg_reg.temperature  <= cfg_wr_data;
                CFG_UPDATE_DELAY: cfg_reg.update_delay <= cfg_wr_data;
            endcase
        end
    end

    lvs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .pop     (pop),
        .q_valid (q_valid),
        .q_ent   (q_ent)
    );

    lvs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_ent   (q_ent),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .stat    (bstat)
    );

    `LVS_ASSERT_NEXT(a_accept_queued, aclk, aresetn, s_valid && s_ready, q_valid)
    `LVS_ASSERT_NEXT(a_result_shown, aclk, aresetn, bstat.out_load, m_valid)
    `LVS_ASSERT_IMPL(a_empty_ready, aclk, aresetn, bstat.idle && !q_valid, s_ready)

endmodule
